// File: hdl/psvm_pkg.sv
// ----------------------------------------------------------------------------
// psvm_pkg: shared types and constants of the PCM sample voice mixer
// Sizes, command codes, register numbers and the queued command format.
// ----------------------------------------------------------------------------
package psvm_pkg;

  localparam int VOICES        = 8;
  localparam int STORE_BYTES   = 65536;
  localparam int FRACTION_BITS = 11;

  localparam int ADDR_W   = $clog2(STORE_BYTES);
  localparam int POS_W    = 16 + FRACTION_BITS;
  localparam int VOL_W    = 9;
  localparam int VOL_RST  = 256;

  // transaction kinds
  typedef enum logic [1:0] {
    FUNC_REG  = 2'd0,
    FUNC_RAM  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // chip register numbers
  localparam logic [3:0] REG_ENV     = 4'd0;
  localparam logic [3:0] REG_PAN     = 4'd1;
  localparam logic [3:0] REG_STEP_LO = 4'd2;
  localparam logic [3:0] REG_STEP_HI = 4'd3;
  localparam logic [3:0] REG_LOOP_LO = 4'd4;
  localparam logic [3:0] REG_LOOP_HI = 4'd5;
  localparam logic [3:0] REG_PAGE    = 4'd6;
  localparam logic [3:0] REG_CTRL    = 4'd7;
  localparam logic [3:0] REG_ENABLE  = 4'd8;

  localparam logic [7:0] LOOP_MARK = 8'hFF;

  typedef struct packed {
    func_e              func;
    logic [3:0]         reg_index;
    logic [7:0]         reg_value;
    logic [15:0]        ram_address;
    logic [7:0]         ram_data;
    logic signed [15:0] fm_sample;
    logic signed [15:0] tone_sample;
    logic signed [15:0] cd_left;
    logic signed [15:0] cd_right;
    logic               cd_valid;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: hdl/psvm_in_if.sv
// ----------------------------------------------------------------------------
// psvm_in_if: input channel of the mixer
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface psvm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [3:0]         reg_index;
  logic [7:0]         reg_value;
  logic [15:0]        ram_address;
  logic [7:0]         ram_data;
  logic signed [15:0] fm_sample;
  logic signed [15:0] tone_sample;
  logic signed [15:0] cd_left;
  logic signed [15:0] cd_right;
  logic               cd_valid;

  modport source (output valid, func, reg_index, reg_value, ram_address, ram_data,
                  fm_sample, tone_sample, cd_left, cd_right, cd_valid, input ready);
  modport sink (input valid, func, reg_index, reg_value, ram_address, ram_data,
                fm_sample, tone_sample, cd_left, cd_right, cd_valid, output ready);
endinterface

// File: hdl/psvm_out_if.sv
// ----------------------------------------------------------------------------
// psvm_out_if: output channel of the mixer
// Valid/ready channel carrying one mixed sample transaction.
// ----------------------------------------------------------------------------
interface psvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;
  logic signed [15:0] voice_left;
  logic signed [15:0] voice_right;

  modport source (output valid, mixed_sample, voice_left, voice_right, input ready);
  modport sink (input valid, mixed_sample, voice_left, voice_right, output ready);
endinterface

// File: hdl/pcm_sample_voice_mixer.sv
// Register and RAM writes pass the input register and the command queue before the voice engine
// executes them; a tick steps the voices only with the chip on, then mixes, scales and saturates.
// The voice engine takes a new command only when idle, and steps one voice at a time through the
// single sample store read port (up to two reads and two multiply steps per voice).
// Reset: control and voice registers clear, volume is 256; the sample store is then zeroed one
// byte per cycle, during which no transaction is accepted.
// ----------------------------------------------------------------------------
// pcm_sample_voice_mixer: eight-voice PCM sample player with final mixer
// Input stage, command queue and voice engine with output register.
// ----------------------------------------------------------------------------
module pcm_sample_voice_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psvm_pkg::VOL_W-1:0]    cfg_wdata_i,
  psvm_in_if.sink                       in_i,
  psvm_out_if.source                    out_o
);
  import psvm_pkg::*;

  cmd_t        f_cmd, q_cmd;
  logic        f_valid, f_ready, q_valid, q_ready;
  back_stat_t  b_stat;
  queue_stat_t q_stat;

  psvm_front u_front (
    .clk_i, .rst_ni, .in_i, .stat_i(b_stat),
    .cmd_o(f_cmd), .cmd_valid_o(f_valid), .cmd_ready_i(f_ready)
  );

  psvm_queue u_queue (
    .clk_i, .rst_ni,
    .push_cmd_i(f_cmd), .push_valid_i(f_valid), .push_ready_o(f_ready),
    .pop_cmd_o(q_cmd), .pop_valid_o(q_valid), .pop_ready_i(q_ready),
    .stat_o(q_stat)
  );

  psvm_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .cmd_i(q_cmd), .cmd_valid_i(q_valid), .cmd_ready_o(q_ready),
    .stat_o(b_stat), .out_o
  );

  // no input taken while the sample store is cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.clearing |-> !in_i.ready) else $error("input accepted during store clear");

  // queue must not report full and empty at once
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty)) else $error("queue full and empty");

  // a full queue holds the input stage
  a_queue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !f_ready) else $error("push into full queue");
endmodule

// File: hdl/psvm_front.sv
// ----------------------------------------------------------------------------
// psvm_front: input stage
// Accepts transactions, drops unused codes and registers a command for the queue.
// ----------------------------------------------------------------------------
module psvm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  psvm_in_if.sink                in_i,
  input  psvm_pkg::back_stat_t   stat_i,
  output psvm_pkg::cmd_t         cmd_o,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i
);
  import psvm_pkg::*;

  logic vld_q;
  cmd_t cmd_q;
  logic accept;

  // stage is free when empty or draining this cycle; closed during store clear
  assign in_i.ready = !stat_i.clearing && (!vld_q || cmd_ready_i);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= (func_e'(in_i.func) != FUNC_NONE);
    end else if (cmd_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.func        <= func_e'(in_i.func);
      cmd_q.reg_index   <= in_i.reg_index;
      cmd_q.reg_value   <= in_i.reg_value;
      cmd_q.ram_address <= in_i.ram_address;
      cmd_q.ram_data    <= in_i.ram_data;
      cmd_q.fm_sample   <= in_i.fm_sample;
      cmd_q.tone_sample <= in_i.tone_sample;
      cmd_q.cd_left     <= in_i.cd_left;
      cmd_q.cd_right    <= in_i.cd_right;
      cmd_q.cd_valid    <= in_i.cd_valid;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = vld_q;
endmodule

// File: hdl/psvm_queue.sv
// ----------------------------------------------------------------------------
// psvm_queue: two-entry command queue
// Decouples the input stage from the voice engine.
// ----------------------------------------------------------------------------
module psvm_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  psvm_pkg::cmd_t          push_cmd_i,
  input  logic                    push_valid_i,
  output logic                    push_ready_o,
  output psvm_pkg::cmd_t          pop_cmd_o,
  output logic                    pop_valid_o,
  input  logic                    pop_ready_i,
  output psvm_pkg::queue_stat_t   stat_o
);
  import psvm_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_cmd_i;
  end
endmodule

// File: hdl/psvm_back.sv
// ----------------------------------------------------------------------------
// psvm_back: voice engine
// Executes register and RAM writes and, with the chip on, steps the voices on each tick,
// then mixes, scales and saturates into the output register.
// ----------------------------------------------------------------------------
module psvm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psvm_pkg::VOL_W-1:0]    cfg_wdata_i,
  input  psvm_pkg::cmd_t                cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  output psvm_pkg::back_stat_t          stat_o,
  psvm_out_if.source                    out_o
);
  import psvm_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_CHK1  = 10'b0000001000,
    S_CHK2  = 10'b0000010000,
    S_SCALE = 10'b0000100000,
    S_PAN   = 10'b0001000000,
    S_MIX   = 10'b0010000000,
    S_VOL   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // voice registers
  logic [7:0]       env_q   [VOICES];
  logic [7:0]       pan_q   [VOICES];
  logic [15:0]      step_q  [VOICES];
  logic [15:0]      loop_q  [VOICES];
  logic [POS_W-1:0] pos_q   [VOICES];
  logic [2:0]       sel_q;
  logic [7:0]       ctrl_q;
  logic [7:0]       en_q;
  logic [VOL_W-1:0] vol_q;

  // tick working registers
  cmd_t               tick_q;
  logic [2:0]         vc_q;
  logic [POS_W-1:0]   posw_q;
  logic [7:0]         smp_q;
  logic signed [12:0] v_q;
  logic signed [15:0] left_q, right_q;
  logic signed [18:0] sum_q;
  logic signed [28:0] prod_q;
  logic [ADDR_W-1:0]  clr_q;

  // output register
  logic               ovld_q;
  logic signed [15:0] omix_q, oleft_q, oright_q;

  // sample store
  logic [7:0]        store_q [STORE_BYTES];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  logic accept, last_voice, out_free, sel_ok;
  logic [POS_W-1:0] loop_pos;

  assign cmd_ready_o     = (state_q == S_IDLE);
  assign accept          = cmd_valid_i && cmd_ready_o;
  assign stat_o.clearing = (state_q == S_CLEAR);
  assign last_voice      = (vc_q == 3'(VOICES - 1));
  assign out_free        = !ovld_q || out_o.ready;
  assign sel_ok          = (sel_q < 3'(VOICES - 1)) || (sel_q == 3'(VOICES - 1));
  assign loop_pos        = {loop_q[vc_q], {FRACTION_BITS{1'b0}}};

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 8'd0;
    mem_re    = 1'b0;
    mem_raddr = pos_q[vc_q][FRACTION_BITS +: ADDR_W];
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && cmd_i.func == FUNC_RAM) begin
      mem_we    = 1'b1;
      mem_waddr = cmd_i.ram_address[ADDR_W-1:0];
      mem_wdata = cmd_i.ram_data;
    end
    if (state_q == S_RD) begin
      mem_re = en_q[vc_q];
    end else if (state_q == S_CHK1) begin
      mem_re    = 1'b1;
      mem_raddr = loop_q[vc_q][ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= store_q[mem_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == {ADDR_W{1'b1}}) state_d = S_IDLE;
      S_IDLE: begin
        if (accept && cmd_i.func == FUNC_TICK) state_d = ctrl_q[7] ? S_RD : S_MIX;
      end
      S_RD: begin
        if (en_q[vc_q]) state_d = S_CHK1;
        else            state_d = last_voice ? S_MIX : S_RD;
      end
      S_CHK1:  state_d = (rdata_q == LOOP_MARK) ? S_CHK2 : S_SCALE;
      S_CHK2: begin
        if (rdata_q == LOOP_MARK) state_d = last_voice ? S_MIX : S_RD;
        else                      state_d = S_SCALE;
      end
      S_SCALE: state_d = S_PAN;
      S_PAN:   state_d = last_voice ? S_MIX : S_RD;
      S_MIX:   state_d = S_VOL;
      S_VOL:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // signed arithmetic of one voice and the mix
  logic [7:0]         mag;
  logic signed [8:0]  smp_s;
  logic signed [17:0] scaled;
  logic signed [17:0] pan_l, pan_r;
  logic signed [16:0] cd_sum, vo_sum;
  logic signed [18:0] mix;
  logic signed [20:0] shifted;
  logic signed [15:0] sat;

  always_comb begin
    mag    = {1'b0, smp_q[6:0]};
    smp_s  = smp_q[7] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
    scaled = 18'(smp_s * $signed({1'b0, env_q[vc_q]}));
    pan_l  = 18'(v_q * $signed({1'b0, pan_q[vc_q][3:0]}));
    pan_r  = 18'(v_q * $signed({1'b0, pan_q[vc_q][7:4]}));
    cd_sum = 17'(tick_q.cd_left) + 17'(tick_q.cd_right);
    vo_sum = 17'(left_q) + 17'(right_q);
    mix    = 19'(tick_q.fm_sample) + 19'(tick_q.tone_sample) + 19'(vo_sum >>> 1);
    if (tick_q.cd_valid) mix = mix + 19'(cd_sum >>> 1);
    shifted = 21'(prod_q >>> 8);
    if (shifted > 21'sd32767)       sat = 16'sh7FFF;
    else if (shifted < -21'sd32768) sat = -16'sh8000;
    else                            sat = shifted[15:0];
  end

  // control and voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      sel_q   <= 3'd0;
      ctrl_q  <= 8'd0;
      en_q    <= 8'd0;
      vol_q   <= VOL_W'(VOL_RST);
      vc_q    <= 3'd0;
      ovld_q  <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        env_q[i]  <= 8'd0;
        pan_q[i]  <= 8'd0;
        step_q[i] <= 16'd0;
        loop_q[i] <= 16'd0;
        pos_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) vol_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      // output valid: set when a result is loaded, cleared when taken
      if (state_q == S_OUT && out_free) ovld_q <= 1'b1;
      else if (out_o.ready)             ovld_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          vc_q <= 3'd0;
          // register write
          if (accept && cmd_i.func == FUNC_REG) begin
            case (cmd_i.reg_index)
              REG_ENV:     if (sel_ok) env_q[sel_q] <= cmd_i.reg_value;
              REG_PAN:     if (sel_ok) pan_q[sel_q] <= cmd_i.reg_value;
              REG_STEP_LO: if (sel_ok) step_q[sel_q][7:0]  <= cmd_i.reg_value;
              REG_STEP_HI: if (sel_ok) step_q[sel_q][15:8] <= cmd_i.reg_value;
              REG_LOOP_LO: if (sel_ok) loop_q[sel_q][7:0]  <= cmd_i.reg_value;
              REG_LOOP_HI: if (sel_ok) loop_q[sel_q][15:8] <= cmd_i.reg_value;
              REG_PAGE: begin
                if (sel_ok) begin
                  pos_q[sel_q] <= {cmd_i.reg_value, {(8 + FRACTION_BITS){1'b0}}};
                end
              end
              REG_CTRL: begin
                if (cmd_i.reg_value[6]) sel_q <= cmd_i.reg_value[2:0];
                ctrl_q <= cmd_i.reg_value;
              end
              REG_ENABLE: en_q <= ~cmd_i.reg_value;
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (!en_q[vc_q] && !last_voice) vc_q <= vc_q + 3'd1;
        end
        S_CHK2: begin
          // silent voice parks at its loop start
          if (rdata_q == LOOP_MARK) begin
            pos_q[vc_q] <= posw_q;
            if (!last_voice) vc_q <= vc_q + 3'd1;
          end
        end
        S_PAN: begin
          pos_q[vc_q] <= posw_q + POS_W'(step_q[vc_q]);
          if (!last_voice) vc_q <= vc_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // tick datapath
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.func == FUNC_TICK) begin
      tick_q  <= cmd_i;
      left_q  <= 16'sd0;
      right_q <= 16'sd0;
    end
    case (state_q)
      S_CHK1: begin
        if (rdata_q == LOOP_MARK) begin
          posw_q <= loop_pos;
        end else begin
          posw_q <= pos_q[vc_q];
          smp_q  <= rdata_q;
        end
      end
      S_CHK2:  smp_q <= rdata_q;
      S_SCALE: v_q   <= 13'(scaled >>> 5);
      S_PAN: begin
        left_q  <= left_q + 16'(pan_l >>> 5);
        right_q <= right_q + 16'(pan_r >>> 5);
      end
      S_MIX:   sum_q  <= mix;
      S_VOL:   prod_q <= 29'(sum_q * $signed({1'b0, vol_q}));
      S_OUT: begin
        if (out_free) begin
          omix_q   <= sat;
          oleft_q  <= left_q;
          oright_q <= right_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = ovld_q;
  assign out_o.mixed_sample = omix_q;
  assign out_o.voice_left   = oleft_q;
  assign out_o.voice_right  = oright_q;
endmodule

// File: test/pcm_sample_voice_mixer_tb.sv
// ----------------------------------------------------------------------------
// pcm_sample_voice_mixer_tb: self-checking bench for the PCM voice mixer
// Drives register, sample RAM and tick transactions with random gaps, predicts
// each mixed sample with a bench-side voice engine model and compares results.
// ----------------------------------------------------------------------------
module pcm_sample_voice_mixer_tb;
  import psvm_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [VOL_W-1:0] cfg_wdata_i = '0;

  psvm_in_if  in_if ();
  psvm_out_if out_if ();

  pcm_sample_voice_mixer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  typedef struct {
    logic [15:0] mixed;
    logic [15:0] left;
    logic [15:0] right;
  } mix_out_t;

  // mirror of the chip state
  logic [VOL_W-1:0] mix_volume;
  logic [7:0]  env_m   [VOICES];
  logic [7:0]  pan_m   [VOICES];
  logic [15:0] step_m  [VOICES];
  logic [15:0] loop_m  [VOICES];
  logic [POS_W-1:0] pos_m [VOICES];
  logic [2:0]  sel_m;
  logic [7:0]  ctrl_m;
  logic [7:0]  ena_m;
  logic [7:0]  sample_mem [STORE_BYTES];

  mix_out_t pending_mix[$];
  int  fail_cnt = 0;
  int  idle_cycles = 0;
  int  out_stall_left;

  // floor division by 2**s
  function automatic longint shr_floor(longint x, int s);
    return x >>> s;
  endfunction

  function automatic void model_reset();
    mix_volume = VOL_W'(VOL_RST);
    for (int v = 0; v < VOICES; v++) begin
      env_m[v] = '0; pan_m[v] = '0; step_m[v] = '0; loop_m[v] = '0; pos_m[v] = '0;
    end
    sel_m = '0; ctrl_m = '0; ena_m = '0;
    for (int a = 0; a < STORE_BYTES; a++) sample_mem[a] = '0;
  endfunction

  // apply one transaction to the mirror; queue a result for ticks
  function automatic void predict_cmd(cmd_t c);
    longint lsum, rsum, acc, vlev;
    logic [POS_W-1:0] p;
    logic [7:0] smp;
    mix_out_t r;
    lsum = 0; rsum = 0;
    case (c.func)
      FUNC_REG: begin
        case (c.reg_index)
          REG_ENV:     env_m[sel_m] = c.reg_value;
          REG_PAN:     pan_m[sel_m] = c.reg_value;
          REG_STEP_LO: step_m[sel_m][7:0] = c.reg_value;
          REG_STEP_HI: step_m[sel_m][15:8] = c.reg_value;
          REG_LOOP_LO: loop_m[sel_m][7:0] = c.reg_value;
          REG_LOOP_HI: loop_m[sel_m][15:8] = c.reg_value;
          REG_PAGE:    pos_m[sel_m] = POS_W'({c.reg_value, 8'd0, 11'd0});
          REG_CTRL: begin
            if (c.reg_value[6]) sel_m = c.reg_value[2:0];
            ctrl_m = c.reg_value;
          end
          REG_ENABLE:  ena_m = ~c.reg_value;
          default: ;
        endcase
      end
      FUNC_RAM: sample_mem[c.ram_address] = c.ram_data;
      FUNC_TICK: begin
        if (ctrl_m[7]) begin
          for (int v = 0; v < VOICES; v++) begin
            if (!ena_m[v]) continue;
            p = pos_m[v];
            smp = sample_mem[p[POS_W-1:FRACTION_BITS]];
            if (smp == LOOP_MARK) begin
              p = POS_W'({loop_m[v], 11'd0});
              smp = sample_mem[p[POS_W-1:FRACTION_BITS]];
              if (smp == LOOP_MARK) begin
                pos_m[v] = p;
                continue;
              end
            end
            vlev = smp[6:0];
            if (!smp[7]) vlev = -vlev;
            vlev = shr_floor(vlev * env_m[v], 5);
            lsum = longint'($signed(16'(lsum + shr_floor(vlev * pan_m[v][3:0], 5))));
            rsum = longint'($signed(16'(rsum + shr_floor(vlev * pan_m[v][7:4], 5))));
            pos_m[v] = p + step_m[v];
          end
        end
        acc = longint'(c.fm_sample) + longint'(c.tone_sample);
        if (c.cd_valid) acc += shr_floor(longint'(c.cd_left) + longint'(c.cd_right), 1);
        acc += shr_floor(lsum + rsum, 1);
        acc = shr_floor(acc * longint'(mix_volume), 8);
        if (acc > 32767) acc = 32767;
        else if (acc < -32768) acc = -32768;
        r.mixed = 16'(acc); r.left = 16'(lsum); r.right = 16'(rsum);
        pending_mix.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // send one transaction, waiting for acceptance; valid stays high for a
  // back-to-back follower and drops before any gap
  task automatic send_cmd(cmd_t c, bit use_gap = 1);
    int gap;
    gap = use_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= c.func;
    in_if.reg_index   <= c.reg_index;
    in_if.reg_value   <= c.reg_value;
    in_if.ram_address <= c.ram_address;
    in_if.ram_data    <= c.ram_data;
    in_if.fm_sample   <= c.fm_sample;
    in_if.tone_sample <= c.tone_sample;
    in_if.cd_left     <= c.cd_left;
    in_if.cd_right    <= c.cd_right;
    in_if.cd_valid    <= c.cd_valid;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    predict_cmd(c);
  endtask

  function automatic cmd_t reg_cmd(logic [3:0] idx, logic [7:0] val);
    cmd_t c;
    c = '0; c.func = FUNC_REG; c.reg_index = idx; c.reg_value = val;
    return c;
  endfunction

  function automatic cmd_t ram_cmd(logic [15:0] adr, logic [7:0] dat);
    cmd_t c;
    c = '0; c.func = FUNC_RAM; c.ram_address = adr; c.ram_data = dat;
    return c;
  endfunction

  function automatic cmd_t tick_cmd();
    cmd_t c;
    c = '0; c.func = FUNC_TICK;
    c.fm_sample = 16'($urandom); c.tone_sample = 16'($urandom);
    c.cd_left = 16'($urandom); c.cd_right = 16'($urandom); c.cd_valid = 1'($urandom);
    // keep external sources small most of the time so voices stay visible
    if ($urandom_range(0, 3) != 0) begin
      c.fm_sample = c.fm_sample >>> 4; c.tone_sample = c.tone_sample >>> 4;
    end
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c = cmd_t'(($bits(cmd_t))'({$urandom, $urandom, $urandom, $urandom}));
    return c;
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_volume(logic [VOL_W-1:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mix_volume = val;
  endtask

  // set up one voice with random envelope and pan
  task automatic setup_voice(int v, logic [7:0] page, logic [15:0] stp, logic [15:0] lp);
    send_cmd(reg_cmd(REG_CTRL, 8'hC0 | 8'(v)));
    send_cmd(reg_cmd(REG_ENV, 8'($urandom_range(0, 255))));
    send_cmd(reg_cmd(REG_PAN, 8'($urandom)));
    send_cmd(reg_cmd(REG_STEP_LO, stp[7:0]));
    send_cmd(reg_cmd(REG_STEP_HI, stp[15:8]));
    send_cmd(reg_cmd(REG_LOOP_LO, lp[7:0]));
    send_cmd(reg_cmd(REG_LOOP_HI, lp[15:8]));
    send_cmd(reg_cmd(REG_PAGE, page));
  endtask

  // chip off, extremes of the external sources, a dropped code and an unused register
  task automatic test_chip_off();
    cmd_t c;
    c = '0; c.func = FUNC_TICK;
    c.fm_sample = 16'sh7FFF; c.tone_sample = 16'sh7FFF;
    c.cd_left = 16'sh7FFF; c.cd_right = 16'sh7FFF; c.cd_valid = 1'b1;
    send_cmd(c);
    c.fm_sample = 16'sh8000; c.tone_sample = 16'sh8000;
    c.cd_left = 16'sh8000; c.cd_right = 16'sh8000;
    send_cmd(c);
    c.cd_valid = 1'b0; c.fm_sample = -16'sd3;
    send_cmd(c);
    c = '0; c.func = FUNC_NONE; c.reg_index = 4'hF;
    send_cmd(c);
    send_cmd(reg_cmd(4'd12, 8'hFF));
  endtask

  // loop marker, silent voice, sign-magnitude extremes
  task automatic test_loop_and_silence();
    send_cmd(ram_cmd(16'h0000, 8'hFF));
    send_cmd(ram_cmd(16'h0010, 8'h7F));
    send_cmd(ram_cmd(16'h0011, 8'hFF));
    send_cmd(ram_cmd(16'h0100, 8'hFF));
    send_cmd(ram_cmd(16'hFFFF, 8'h80));
    send_cmd(reg_cmd(REG_CTRL, 8'hC0));
    send_cmd(reg_cmd(REG_ENV, 8'hFF));
    send_cmd(reg_cmd(REG_PAN, 8'hFF));
    send_cmd(reg_cmd(REG_STEP_HI, 8'h08));
    send_cmd(reg_cmd(REG_LOOP_LO, 8'h10));
    send_cmd(reg_cmd(REG_ENABLE, 8'hFE));
    repeat (4) send_cmd(tick_cmd());
    // silent voice: loop start points at a loop marker too
    send_cmd(reg_cmd(REG_CTRL, 8'hC1));
    send_cmd(reg_cmd(REG_LOOP_HI, 8'h01));
    send_cmd(reg_cmd(REG_ENABLE, 8'hFC));
    repeat (3) send_cmd(tick_cmd());
    // chip off keeps positions frozen
    send_cmd(reg_cmd(REG_CTRL, 8'h41));
    send_cmd(tick_cmd());
    // bank select form keeps the voice selection
    send_cmd(reg_cmd(REG_CTRL, 8'h87));
    send_cmd(tick_cmd());
  endtask

  // wrap of position at the top of the store
  task automatic test_position_wrap();
    send_cmd(reg_cmd(REG_CTRL, 8'hC2));
    send_cmd(reg_cmd(REG_ENV, 8'h80));
    send_cmd(reg_cmd(REG_PAN, 8'h5A));
    send_cmd(reg_cmd(REG_STEP_LO, 8'hFF));
    send_cmd(reg_cmd(REG_STEP_HI, 8'hFF));
    send_cmd(reg_cmd(REG_PAGE, 8'hFF));
    send_cmd(reg_cmd(REG_ENABLE, 8'h00));
    send_cmd(reg_cmd(REG_CTRL, 8'h80));
    repeat (6) send_cmd(tick_cmd());
  endtask

  // random stream: mostly voice setups, RAM fills and ticks, some noise
  task automatic test_random_mix(int n_items);
    int sent;
    int pick;
    logic [15:0] base;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        setup_voice($urandom_range(0, 7), 8'($urandom_range(0, 3)),
                    16'($urandom_range(0, 4096)), 16'($urandom_range(0, 1023)));
        send_cmd(reg_cmd(REG_CTRL, 8'h80 | 8'($urandom)));
        send_cmd(reg_cmd(REG_ENABLE, 8'($urandom)));
        sent += 10;
      end else if (pick < 30) begin
        base = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
        send_cmd(ram_cmd(base, ($urandom_range(0, 7) == 0) ? LOOP_MARK : 8'($urandom)));
        sent++;
      end else if (pick < 37) begin
        send_cmd(rand_cmd());
        sent++;
      end else begin
        send_cmd(tick_cmd());
        sent++;
      end
      if (sent % 150 == 0) wait_drained();
    end
  endtask

  task automatic test_volume_sweep();
    write_volume(9'd0);
    repeat (5) send_cmd(tick_cmd());
    write_volume(9'h1FF);
    repeat (5) send_cmd(tick_cmd());
    write_volume(9'd1);
    repeat (5) send_cmd(tick_cmd());
  endtask

  // result check
  always @(posedge clk_i) begin
    mix_out_t e;
    if (out_if.valid && out_if.ready) begin
      if (pending_mix.size() == 0) begin
        $error("unexpected result transaction");
        fail_cnt++;
      end else begin
        e = pending_mix.pop_front();
        if (out_if.mixed_sample !== e.mixed) begin
          $error("mixed_sample exp %0d got %0d", $signed(e.mixed), out_if.mixed_sample);
          fail_cnt++;
        end
        if (out_if.voice_left !== e.left) begin
          $error("voice_left exp %0d got %0d", $signed(e.left), out_if.voice_left);
          fail_cnt++;
        end
        if (out_if.voice_right !== e.right) begin
          $error("voice_right exp %0d got %0d", $signed(e.right), out_if.voice_right);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stalls: short random gaps, occasional long ones
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_ni) begin
      out_if.ready   <= 1'b1;
      out_stall_left <= 0;
    end else if (out_stall_left > 0) begin
      out_if.ready   <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (r < 2) begin
      out_if.ready   <= 1'b0;
      out_stall_left <= $urandom_range(10, 60);
    end else if (r < 25) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted transaction; the limit covers the clearing pass
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.func = '0; in_if.reg_index = '0; in_if.reg_value = '0;
    in_if.ram_address = '0; in_if.ram_data = '0;
    in_if.fm_sample = '0; in_if.tone_sample = '0;
    in_if.cd_left = '0; in_if.cd_right = '0; in_if.cd_valid = 1'b0;
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_volume(9'd256);
    test_chip_off();
    test_loop_and_silence();
    test_position_wrap();
    test_random_mix(250);
    test_volume_sweep();
    write_volume(9'd200);
    test_random_mix(300);
    write_volume(9'd256);
    wait_drained();
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
